// File: hw/rtl/tpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpf_pkg: shared types and constants of the telemetry packet framer
// Item layout, opcodes, frame layout, frame descriptor and the CRC-8 step.
// ----------------------------------------------------------------------------
package tpf_pkg;

  // Input item fields
  localparam int unsigned OPCODE_W  = 2;
  localparam int unsigned BUTTON_W  = 7;
  localparam int unsigned TEMP_W    = 16;
  localparam int unsigned IN_DATA_W = 32;

  // Output item and configuration port
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned NODE_ID_W  = 16;
  localparam int unsigned SEQ_W      = 8;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [NODE_ID_W-1:0] NODE_ID_RESET = 16'hD281;

  // Register index of node_id on the configuration port
  localparam logic REG_NODE_ID = 1'b0;

  // CRC-8, polynomial x^8 + x^2 + x + 1, init 0, MSB first
  localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;
  localparam logic [BYTE_W-1:0] CRC_INIT = 8'h00;

  // Options byte: bit 1 always set, bit 0 carries the ack request
  localparam logic [BYTE_W-1:0] OPT_CRC = 8'h02;

  // Frame layout
  localparam int unsigned FRAME_LEN = 8;
  localparam int unsigned IDX_W     = $clog2(FRAME_LEN);

  localparam logic [IDX_W-1:0] BYTE_ID_HI  = 3'd0;
  localparam logic [IDX_W-1:0] BYTE_ID_LO  = 3'd1;
  localparam logic [IDX_W-1:0] BYTE_SEQ    = 3'd2;
  localparam logic [IDX_W-1:0] BYTE_OPT    = 3'd3;
  localparam logic [IDX_W-1:0] BYTE_TEMP_L = 3'd4;
  localparam logic [IDX_W-1:0] BYTE_TEMP_H = 3'd5;
  localparam logic [IDX_W-1:0] BYTE_BUTTON = 3'd6;
  localparam logic [IDX_W-1:0] BYTE_CRC    = 3'd7;

  // Descriptor queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [OPCODE_W-1:0] {
    OP_BUTTON = 2'd0,
    OP_ACK    = 2'd1,
    OP_SEND   = 2'd2
  } opcode_t;

  // Everything the back end needs to frame one packet
  typedef struct packed {
    logic [NODE_ID_W-1:0] node_id;
    logic [SEQ_W-1:0]     seq;
    logic                 ack;
    logic [TEMP_W-1:0]    temp;
    logic [BUTTON_W-1:0]  buttons;
  } frame_desc_t;

  // Fold one byte into the running CRC
  function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] v;
    v = crc ^ b;
    for (int i = 0; i < BYTE_W; i++) begin
      if (v[BYTE_W-1]) begin
        v = {v[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[BYTE_W-2:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

// File: hw/rtl/telemetry_packet_framer_crc8_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telemetry_packet_framer_crc8_unit: telemetry packet framer with CRC-8
// Latches button events and ack requests and frames 8-byte packets on send.
// ----------------------------------------------------------------------------
// Button-event and ack-tick items are taken one per cycle while the queue
// has room and produce no output. A send item is taken likewise and queued;
// the serializer then emits its eight bytes at one byte per cycle while
// out_tready is high (node id high, node id low, sequence, options,
// temperature low, temperature high, buttons, CRC), with tlast on the CRC
// byte, back to back with the next queued packet. The serializer thus sets
// the sustained send rate; a two-entry descriptor queue lets intake run
// ahead; in_tready drops only while that queue is full. node_id sits at byte
// address 0 of the register port and is to be written only while idle.
// ----------------------------------------------------------------------------
module telemetry_packet_framer_crc8_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  // register port
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [tpf_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [tpf_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [tpf_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready,
  // input items
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [1:0] opcode, [8:2] button_events, [24:9] temperature, [31:25] zero
  input  logic [tpf_pkg::IN_DATA_W-1:0]  in_tdata,
  // result items
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [7:0] packet_byte
  output logic [tpf_pkg::BYTE_W-1:0]     out_tdata,
  // last_byte
  output logic                           out_tlast
);
  import tpf_pkg::*;

  logic        push_valid;
  logic        push_ready;
  frame_desc_t push_desc;
  logic        pop_valid;
  logic        pop_ready;
  frame_desc_t pop_desc;

  tpf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_desc   (push_desc)
  );

  // The front drives valid; ready comes back from the queue
  tpf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_desc  (push_desc),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_desc   (pop_desc)
  );

  tpf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_desc   (pop_desc),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// File: hw/rtl/tpf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpf_front: item intake and sticky state of the framer
// Holds node_id, sequence number, button latches and the ack request, and
// pushes one frame descriptor into the queue for every send item.
// ----------------------------------------------------------------------------
module tpf_front (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration port
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [tpf_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [tpf_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [tpf_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready,
  // input items
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [tpf_pkg::IN_DATA_W-1:0]  in_tdata,
  // descriptor queue write side
  output logic                           push_valid,
  input  logic                           push_ready,
  output tpf_pkg::frame_desc_t           push_desc
);
  import tpf_pkg::*;

  logic [NODE_ID_W-1:0] node_id_r, node_id_nxt;
  logic [SEQ_W-1:0]     seq_r, seq_nxt;
  logic [BUTTON_W-1:0]  button_r, button_nxt;
  logic                 ack_r, ack_nxt;

  logic                 cfg_wr;
  logic                 accept;
  logic [OPCODE_W-1:0]  opcode;
  logic [BUTTON_W-1:0]  events;
  logic [TEMP_W-1:0]    temp;

  // Unpack the item
  assign opcode = in_tdata[OPCODE_W-1:0];
  assign events = in_tdata[OPCODE_W +: BUTTON_W];
  assign temp   = in_tdata[OPCODE_W+BUTTON_W +: TEMP_W];

  // Register access
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_NODE_ID) ?
                      {{(CFG_DATA_W-NODE_ID_W){1'b0}}, node_id_r} : '0;

  // Stall only when the queue has no room for a descriptor
  assign in_tready  = push_ready;
  assign accept     = in_tvalid && in_tready;
  assign push_valid = accept && (opcode == OP_SEND);

  assign push_desc.node_id = node_id_r;
  assign push_desc.seq     = seq_r;
  assign push_desc.ack     = ack_r;
  assign push_desc.temp    = temp;
  assign push_desc.buttons = button_r;

  // Update sticky state per opcode
  always_comb begin
    node_id_nxt = node_id_r;
    seq_nxt     = seq_r;
    button_nxt  = button_r;
    ack_nxt     = ack_r;
    if (cfg_wr && (cfg_paddr[2] == REG_NODE_ID)) begin
      node_id_nxt = cfg_pwdata[NODE_ID_W-1:0];
    end
    if (accept) begin
      case (opcode)
        OP_BUTTON: begin
          button_nxt = button_r | events;
        end
        OP_ACK: begin
          ack_nxt = 1'b1;
        end
        OP_SEND: begin
          seq_nxt    = seq_r + 1'b1;
          button_nxt = '0;
          ack_nxt    = 1'b0;
        end
        default: begin
          // unused opcode: drop the item
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_id_r <= NODE_ID_RESET;
      seq_r     <= '0;
      button_r  <= '0;
      ack_r     <= 1'b0;
    end else begin
      node_id_r <= node_id_nxt;
      seq_r     <= seq_nxt;
      button_r  <= button_nxt;
      ack_r     <= ack_nxt;
    end
  end

endmodule

// File: hw/rtl/tpf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpf_queue: frame descriptor queue
// Short FIFO that decouples item intake from byte serialization.
// ----------------------------------------------------------------------------
module tpf_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  tpf_pkg::frame_desc_t push_desc,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output tpf_pkg::frame_desc_t pop_desc
);
  import tpf_pkg::*;

  frame_desc_t         entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                do_push, do_pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_desc   = entry_r[rd_ptr_r];

  assign do_push = push_valid && push_ready;
  assign do_pop  = pop_valid && pop_ready;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the descriptor
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

// File: hw/rtl/tpf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpf_back: packet byte serializer
// Walks one descriptor through its eight bytes, folds each into the CRC and
// drives the result items from an output register.
// ----------------------------------------------------------------------------
module tpf_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       pop_valid,
  output logic                       pop_ready,
  input  tpf_pkg::frame_desc_t       pop_desc,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [tpf_pkg::BYTE_W-1:0] out_tdata,
  output logic                       out_tlast
);
  import tpf_pkg::*;

  frame_desc_t        frame_r, frame_nxt;
  logic               active_r, active_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [BYTE_W-1:0]  crc_r, crc_nxt;
  logic               valid_r, valid_nxt;
  logic [BYTE_W-1:0]  data_r, data_nxt;
  logic               last_r, last_nxt;

  logic               load;
  logic               at_last;
  logic [BYTE_W-1:0]  cur_byte;

  assign at_last   = (idx_r == BYTE_CRC);
  assign load      = active_r && (!valid_r || out_tready);
  assign pop_ready = !active_r || (load && at_last);

  // Pick the byte at the current position
  always_comb begin
    case (idx_r)
      BYTE_ID_HI:  cur_byte = frame_r.node_id[NODE_ID_W-1 -: BYTE_W];
      BYTE_ID_LO:  cur_byte = frame_r.node_id[BYTE_W-1:0];
      BYTE_SEQ:    cur_byte = frame_r.seq;
      BYTE_OPT:    cur_byte = OPT_CRC | {{(BYTE_W-1){1'b0}}, frame_r.ack};
      BYTE_TEMP_L: cur_byte = frame_r.temp[BYTE_W-1:0];
      BYTE_TEMP_H: cur_byte = frame_r.temp[TEMP_W-1 -: BYTE_W];
      BYTE_BUTTON: cur_byte = {{(BYTE_W-BUTTON_W){1'b0}}, frame_r.buttons};
      BYTE_CRC:    cur_byte = crc_r;
      default:     cur_byte = crc_r;
    endcase
  end

  // Sequence bytes, running CRC and the output register
  always_comb begin
    frame_nxt  = frame_r;
    active_nxt = active_r;
    idx_nxt    = idx_r;
    crc_nxt    = crc_r;
    valid_nxt  = valid_r;
    data_nxt   = data_r;
    last_nxt   = last_r;

    if (load) begin
      valid_nxt = 1'b1;
      data_nxt  = cur_byte;
      last_nxt  = at_last;
      idx_nxt   = idx_r + 1'b1;
      crc_nxt   = crc8_byte(crc_r, cur_byte);
      if (at_last) begin
        active_nxt = 1'b0;
      end
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end

    // Take the next descriptor as the current frame ends or while idle
    if (pop_valid && pop_ready) begin
      frame_nxt  = pop_desc;
      active_nxt = 1'b1;
      idx_nxt    = BYTE_ID_HI;
      crc_nxt    = CRC_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      idx_r    <= BYTE_ID_HI;
      crc_r    <= CRC_INIT;
      valid_r  <= 1'b0;
    end else begin
      active_r <= active_nxt;
      idx_r    <= idx_nxt;
      crc_r    <= crc_nxt;
      valid_r  <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frame_r <= frame_nxt;
    data_r  <= data_nxt;
    last_r  <= last_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

endmodule
